>>> rtl/core/ppf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the packet payload pattern filter: register
// indexes, reset values, verdict causes and frame layout positions.
// ----------------------------------------------------------------------------
package ppf_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_NUMBER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCAN        = 2'd3;

    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PROTO_W    = 8;
    localparam int unsigned NEEDLE_W   = 40;
    localparam int unsigned SCAN_W     = 16;

    localparam logic [ADDR_W-1:0]   RST_SOURCE_ADDRESS  = 32'd167837697;
    localparam logic [PROTO_W-1:0]  RST_PROTOCOL_NUMBER = 8'd6;
    localparam logic [NEEDLE_W-1:0] RST_NEEDLE_BYTES    = 40'd362272688200;
    localparam logic [SCAN_W-1:0]   RST_MAX_SCAN        = 16'd1550;

    // Default needle length in bytes (legal range 1 to 8).
    localparam int unsigned NEEDLE_BYTES_DEF = 5;

    // Frame layout and length limits.
    localparam int unsigned COUNT_W         = 17;
    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned MIN_FRAME_BYTES = 34;
    localparam int unsigned ADDR_FIRST      = 26;
    localparam int unsigned ADDR_LAST       = 29;
    localparam int unsigned PROTO_POS       = 23;

    // Verdict causes.
    localparam int unsigned CAUSE_W = 3;
    localparam logic [CAUSE_W-1:0] CAUSE_NOT_SELECTED = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_MATCH     = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_TOO_SHORT    = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_TOO_LONG     = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_NEEDLE_FOUND = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_SCAN_LIMIT   = 3'd5;

    // Configuration handed from the register file to the inspection engine.
    typedef struct packed {
        logic [ADDR_W-1:0]   source_address;
        logic [PROTO_W-1:0]  protocol_number;
        logic [NEEDLE_W-1:0] needle_bytes;
        logic [SCAN_W-1:0]   max_scan;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/core/ppf_inspect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_inspect
// Per-frame state of the filter: byte counter, needle window, header capture
// and match flags, updated once per frame byte, with the verdict of the
// frame formed on its final byte.
// ----------------------------------------------------------------------------
module ppf_inspect #(
    parameter int unsigned NEEDLE_BYTES = ppf_pkg::NEEDLE_BYTES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire ppf_pkg::t_cfg               i_cfg,
    input  wire                              i_step,
    input  wire [7:0]                        i_frame_byte,
    input  wire                              i_end_of_frame,
    output logic                             o_drop,
    output logic [ppf_pkg::CAUSE_W-1:0]      o_cause
);

    localparam int unsigned WIN_W = 8 * NEEDLE_BYTES;
    localparam int unsigned CW    = ppf_pkg::COUNT_W;

    logic [CW-1:0]                  r_byte_count, n_byte_count;
    logic [WIN_W-1:0]               r_window, n_window;
    logic [ppf_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [ppf_pkg::PROTO_W-1:0]    r_proto, n_proto;
    logic                           r_match, n_match;
    logic                           r_limit, n_limit;

    logic [WIN_W+7:0]               win_ext;
    logic [WIN_W-1:0]               win;
    logic [63:0]                    needle_ext;
    logic [WIN_W-1:0]               needle_w;
    logic [CW-1:0]                  scan_end;
    logic                           in_window;
    logic [CW-1:0]                  len;
    logic                           upd_match, upd_limit;
    logic [ppf_pkg::ADDR_W-1:0]     upd_addr;
    logic [ppf_pkg::PROTO_W-1:0]    upd_proto;

    assign win_ext    = {r_window, i_frame_byte};
    assign win        = win_ext[WIN_W-1:0];
    assign needle_ext = {{(64-ppf_pkg::NEEDLE_W){1'b0}}, i_cfg.needle_bytes};
    assign needle_w   = needle_ext[WIN_W-1:0];

    // Start offset s = count - (N-1) lies beyond the limit when
    // count > max_scan + (N-1); the sum fits in the counter width.
    assign scan_end  = {1'b0, i_cfg.max_scan} + CW'(NEEDLE_BYTES - 1);
    assign in_window = (r_byte_count >= CW'(NEEDLE_BYTES - 1)) && !r_byte_count[CW-1];

    always_comb begin
        upd_addr  = r_addr;
        upd_proto = r_proto;
        upd_match = r_match;
        upd_limit = r_limit;
        if (r_byte_count >= CW'(ppf_pkg::ADDR_FIRST) &&
            r_byte_count <= CW'(ppf_pkg::ADDR_LAST)) begin
            upd_addr = {r_addr[ppf_pkg::ADDR_W-9:0], i_frame_byte};
        end
        if (r_byte_count == CW'(ppf_pkg::PROTO_POS)) begin
            upd_proto = i_frame_byte;
        end
        if (in_window) begin
            if (r_byte_count > scan_end) begin
                upd_limit = 1'b1;
            end else if (win == needle_w) begin
                upd_match = 1'b1;
            end
        end
        // The counter stops at 65536 so an overlong frame stays too long.
        len = r_byte_count[CW-1] ? r_byte_count : r_byte_count + CW'(1);
    end

    always_comb begin
        if (len > CW'(ppf_pkg::MAX_FRAME_BYTES)) begin
            o_cause = ppf_pkg::CAUSE_TOO_LONG;
        end else if (len < CW'(ppf_pkg::MIN_FRAME_BYTES)) begin
            o_cause = ppf_pkg::CAUSE_TOO_SHORT;
        end else if (upd_addr != i_cfg.source_address ||
                     upd_proto != i_cfg.protocol_number) begin
            o_cause = ppf_pkg::CAUSE_NOT_SELECTED;
        end else if (upd_match) begin
            o_cause = ppf_pkg::CAUSE_NEEDLE_FOUND;
        end else if (upd_limit) begin
            o_cause = ppf_pkg::CAUSE_SCAN_LIMIT;
        end else begin
            o_cause = ppf_pkg::CAUSE_NO_MATCH;
        end
        o_drop = (o_cause >= ppf_pkg::CAUSE_TOO_SHORT);
    end

    always_comb begin
        n_byte_count = r_byte_count;
        n_window     = r_window;
        n_addr       = r_addr;
        n_proto      = r_proto;
        n_match      = r_match;
        n_limit      = r_limit;
        if (i_step) begin
            if (i_end_of_frame) begin
                n_byte_count = '0;
                n_window     = '0;
                n_addr       = '0;
                n_proto      = '0;
                n_match      = 1'b0;
                n_limit      = 1'b0;
            end else begin
                n_byte_count = len;
                n_window     = win;
                n_addr       = upd_addr;
                n_proto      = upd_proto;
                n_match      = upd_match;
                n_limit      = upd_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_window     <= '0;
            r_addr       <= '0;
            r_proto      <= '0;
            r_match      <= 1'b0;
            r_limit      <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_window     <= n_window;
            r_addr       <= n_addr;
            r_proto      <= n_proto;
            r_match      <= n_match;
            r_limit      <= n_limit;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/packet_payload_pattern_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_payload_pattern_filter
// Byte-stream frame filter giving one pass or drop verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle, with no gaps needed between
// frames, unless a final byte waits on a stalled, full output register.
// Each accepted item passes through an input register and is folded into
// the per-frame state as it leaves; the byte that carries end of frame
// then also loads one verdict item into the output register, held there
// until taken. Non-final bytes produce no item. The window compare and
// counter update are combinational. A frame is inspected only if its IPv4
// source address (bytes 26 to 29) and protocol byte (byte 23) match the
// configuration; inspected frames are dropped when the needle starts at an
// offset up to max_scan, or when a window starts beyond it. Frames under 34
// or over 65535 bytes are always dropped. Configuration must be written
// only while no frame is in flight (not enforced); the port is always ready.
module packet_payload_pattern_filter #(
    parameter int unsigned NEEDLE_BYTES = ppf_pkg::NEEDLE_BYTES_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input byte channel.
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [7:0]                           i_frame_byte,
    input  wire                                 i_end_of_frame,
    // Verdict channel.
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_drop,
    output logic [ppf_pkg::CAUSE_W-1:0]         o_cause,
    // Configuration write channel.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [ppf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [ppf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    ppf_pkg::t_cfg                  r_cfg, n_cfg;

    logic                           r_s1_valid, n_s1_valid;
    logic [7:0]                     r_s1_byte;
    logic                           r_s1_eof;

    logic                           r_out_valid, n_out_valid;
    logic                           r_out_drop;
    logic [ppf_pkg::CAUSE_W-1:0]    r_out_cause;

    logic                           in_acc;
    logic                           out_free;
    logic                           s1_go;
    logic                           out_load;
    logic                           v_drop;
    logic [ppf_pkg::CAUSE_W-1:0]    v_cause;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppf_pkg::CFG_SOURCE_ADDRESS:
                    n_cfg.source_address = i_cfg_data[ppf_pkg::ADDR_W-1:0];
                ppf_pkg::CFG_PROTOCOL_NUMBER:
                    n_cfg.protocol_number = i_cfg_data[ppf_pkg::PROTO_W-1:0];
                ppf_pkg::CFG_NEEDLE_BYTES:
                    n_cfg.needle_bytes = i_cfg_data[ppf_pkg::NEEDLE_W-1:0];
                ppf_pkg::CFG_MAX_SCAN:
                    n_cfg.max_scan = i_cfg_data[ppf_pkg::SCAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A non-final byte never needs the output register, so only a final
    // byte waits for it.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1_eof || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = s1_go && r_s1_eof;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    ppf_inspect #(
        .NEEDLE_BYTES (NEEDLE_BYTES)
    ) u_inspect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_step         (s1_go),
        .i_frame_byte   (r_s1_byte),
        .i_end_of_frame (r_s1_eof),
        .o_drop         (v_drop),
        .o_cause        (v_cause)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_address  <= ppf_pkg::RST_SOURCE_ADDRESS;
            r_cfg.protocol_number <= ppf_pkg::RST_PROTOCOL_NUMBER;
            r_cfg.needle_bytes    <= ppf_pkg::RST_NEEDLE_BYTES;
            r_cfg.max_scan        <= ppf_pkg::RST_MAX_SCAN;
            r_s1_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_frame_byte;
            r_s1_eof  <= i_end_of_frame;
        end
        if (out_load) begin
            r_out_drop  <= v_drop;
            r_out_cause <= v_cause;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drop      = r_out_drop;
    assign o_cause     = r_out_cause;

endmodule
`default_nettype wire
